// File: rtl/dve_pkg.sv
`default_nettype none

package dve_pkg;

  localparam int unsigned NumberWidthDef = 12;
  localparam int unsigned StackDepthDef  = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new number and restart the trials
    logic div_start;   // start dividing the number by the current trial value
    logic take_trial;  // present the trial value and push its counterpart
    logic step_trial;  // advance to the next trial value
    logic pop;         // read the top of the stack into the output register
  } dve_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trial_ok;     // trial value squared does not exceed the number
    logic div_done;     // divider finished this cycle
    logic div_exact;    // remainder of the finished division is zero
    logic stack_empty;  // no counterparts left on the stack
  } dve_status_t;

endpackage

`default_nettype wire

// File: rtl/dve_if.sv
`default_nettype none

interface dve_in_if #(
  parameter int unsigned NUMBER_WIDTH = 12
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface dve_out_if #(
  parameter int unsigned NUMBER_WIDTH = 12
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] divisor;
  logic                    last;

  modport source (output valid, output divisor, output last, input ready);
  modport sink   (input valid, input divisor, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/dve_divider.sv
`default_nettype none

module dve_divider
  import dve_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = NumberWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [NUMBER_WIDTH-1:0] dividend_i,
  input  wire logic [NUMBER_WIDTH-1:0] divisor_i,
  output logic                         done_o,
  output logic [NUMBER_WIDTH-1:0]      quotient_o,
  output logic [NUMBER_WIDTH-1:0]      remainder_o
);

  localparam int unsigned CntWidth = $clog2(NUMBER_WIDTH + 1);

  logic [NUMBER_WIDTH-1:0] rem_q, rem_d;
  logic [NUMBER_WIDTH-1:0] quo_q, quo_d;
  logic [NUMBER_WIDTH-1:0] div_q;
  logic [CntWidth-1:0]     cnt_q;
  logic                    busy_q;
  logic                    done_q;
  logic [NUMBER_WIDTH:0]   shifted;
  logic [NUMBER_WIDTH:0]   diff;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shifted = {rem_q, quo_q[NUMBER_WIDTH-1]};
    diff    = shifted - {1'b0, div_q};
    if (!diff[NUMBER_WIDTH]) begin
      rem_d = diff[NUMBER_WIDTH-1:0];
      quo_d = {quo_q[NUMBER_WIDTH-2:0], 1'b1};
    end else begin
      rem_d = shifted[NUMBER_WIDTH-1:0];
      quo_d = {quo_q[NUMBER_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(NUMBER_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntWidth'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// File: rtl/dve_datapath.sv
`default_nettype none

module dve_datapath
  import dve_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = NumberWidthDef,
  parameter int unsigned STACK_DEPTH  = StackDepthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dve_cmd_t                cmd_i,
  output dve_status_t                  status_o,
  input  wire logic [NUMBER_WIDTH-1:0] number_i,
  output logic [NUMBER_WIDTH-1:0]      divisor_o,
  output logic                         last_o
);

  localparam int unsigned TrialWidth = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int unsigned SqWidth    = 2 * TrialWidth;
  localparam int unsigned SpWidth    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrWidth  = $clog2(STACK_DEPTH);

  logic [NUMBER_WIDTH-1:0] num_q;
  logic [TrialWidth-1:0]   trial_q;
  logic [SpWidth-1:0]      sp_q;
  logic [SpWidth-1:0]      sp_dec;
  logic [NUMBER_WIDTH-1:0] stack_mem [STACK_DEPTH];
  logic [NUMBER_WIDTH-1:0] out_div_q;
  logic                    out_last_q;

  logic [SqWidth-1:0]      trial_sq;
  logic [NUMBER_WIDTH-1:0] trial_ext;
  logic [NUMBER_WIDTH-1:0] quotient;
  logic [NUMBER_WIDTH-1:0] remainder;
  logic                    div_done;
  logic                    is_root;
  logic                    push;

  assign trial_sq  = SqWidth'(trial_q) * SqWidth'(trial_q);
  assign trial_ext = {{(NUMBER_WIDTH-TrialWidth){1'b0}}, trial_q};
  assign sp_dec    = sp_q - 1'b1;
  assign is_root   = (quotient == trial_ext);
  // A counterpart that finds the stack full is dropped.
  assign push      = cmd_i.take_trial && !is_root && (sp_q < SpWidth'(STACK_DEPTH));

  dve_divider #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (trial_ext),
    .done_o     (div_done),
    .quotient_o (quotient),
    .remainder_o(remainder)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (cmd_i.load) begin
      sp_q <= '0;
    end else if (push) begin
      sp_q <= sp_q + 1'b1;
    end else if (cmd_i.pop) begin
      sp_q <= sp_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q   <= number_i;
      trial_q <= TrialWidth'(1);
    end else if (cmd_i.step_trial) begin
      trial_q <= trial_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[sp_q[AddrWidth-1:0]] <= quotient;
    end
  end

  // The output register doubles as the registered read port of the stack.
  // A trial divisor closes the run only when it is the square root and
  // nothing was pushed before it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_trial) begin
      out_div_q  <= trial_ext;
      out_last_q <= is_root && (sp_q == '0);
    end else if (cmd_i.pop) begin
      out_div_q  <= stack_mem[sp_dec[AddrWidth-1:0]];
      out_last_q <= (sp_q == SpWidth'(1));
    end
  end

  assign status_o.trial_ok    = (trial_sq <= {{(SqWidth-NUMBER_WIDTH){1'b0}}, num_q});
  assign status_o.div_done    = div_done;
  assign status_o.div_exact   = (remainder == '0);
  assign status_o.stack_empty = (sp_q == '0);

  assign divisor_o = out_div_q;
  assign last_o    = out_last_q;

endmodule

`default_nettype wire

// File: rtl/dve_ctrl.sv
`default_nettype none

module dve_ctrl
  import dve_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire dve_status_t status_i,
  output dve_cmd_t         cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StEmit  = 3'd3;
  localparam logic [2:0] StPop   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (status_i.trial_ok) begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end else if (status_i.stack_empty) begin
          state_d = StIdle;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = StPop;
        end
      end
      StDiv: begin
        if (status_i.div_done) begin
          if (status_i.div_exact) begin
            cmd_o.take_trial = 1'b1;
            state_d          = StEmit;
          end else begin
            cmd_o.step_trial = 1'b1;
            state_d          = StCheck;
          end
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.step_trial = 1'b1;
          state_d          = StCheck;
        end
      end
      StPop: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.stack_empty) begin
            state_d = StIdle;
          end else begin
            cmd_o.pop = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/divisor_enumerator.sv
// Divisor enumerator: lists every divisor of a number in ascending order.
// The input channel carries one number per transaction; the output channel
// carries one divisor per transaction, with last set on the final divisor
// of the run. A number of zero produces no output transactions at all.
// Trial values 1, 2, ... are tried while their square does not exceed the
// number. Each trial passes through a compare step and then the
// bit-serial divider, which dominates the running time. Small divisors
// leave as they are found; their counterparts go onto a stack and are
// popped, one per cycle while the receiver is ready, after the trials.
// The block takes one number at a time: in ready is high only while idle.
// If the receiver stalls, the current divisor holds in the output register
// and the search pauses until the transaction completes.
// Reset returns the block to idle with an empty stack; no clearing pass.
`default_nettype none

module divisor_enumerator
  import dve_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = NumberWidthDef,
  parameter int unsigned STACK_DEPTH  = StackDepthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dve_in_if.sink      in_if,
  dve_out_if.source   out_if
);

  dve_cmd_t    cmd;
  dve_status_t status;

  dve_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dve_datapath #(
    .NUMBER_WIDTH(NUMBER_WIDTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .number_i (in_if.number),
    .divisor_o(out_if.divisor),
    .last_o   (out_if.last)
  );

`ifndef NO_ASSERTIONS
  // The block never takes a new number while a divisor is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid))
    else $error("input ready while output valid");

  // The block is still busy in the cycle after a number is taken.
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input ready right after a transaction");

  // The final divisor of a run is never followed at once by another one.
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && out_if.last) |=> !out_if.valid)
    else $error("output valid right after the last divisor");

  // A division is started only when the trial value is still in range.
  a_div_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> status.trial_ok)
    else $error("division started beyond the square root");
`endif

endmodule

`default_nettype wire
